// File: hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue with search.
`default_nettype none

package deq_pkg;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    take;
        logic    write;
        logic    read;
        logic    pop_capture;
        logic    pop_commit;
        logic    scan_start;
        logic    scan_next;
        logic    set_found;
        logic    set_status;
        status_t status;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                empty;
        logic                full;
        logic                scan_hit;
        logic                scan_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/deq_if.sv
// Handshake channels for queue commands and responses.
`default_nettype none

interface deq_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::OPCODE_W-1:0]        opcode;
    logic signed [deq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [deq_pkg::VALUE_W-1:0]  result_value;
    logic                                found;
    logic [deq_pkg::STATUS_W-1:0]        status;
    logic [deq_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, output result_value, output found, output status,
                    output entry_count, input ready);
    modport sink (input valid, input result_value, input found, input status,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/array_deque_with_search_core.sv
// Top level of the bounded double-ended queue of signed words with value search.
//
// The cmd channel takes one word per operation: opcode (push back, push front,
// pop front, pop back, search) and value. The rsp channel returns exactly one
// word per command: popped value, found flag, status and entry count after it.
// Entries live in a single-port ring memory of CAPACITY words addressed from a
// head pointer, so each command runs through the controller one at a time.
// A push, an unused code or a search of an empty queue runs through the execute
// and done states before the response register loads; a pop adds a read state for
// the registered memory read. A search reads one entry per cycle in the scan state
// and ends on a hit or once the last held entry has been compared.
// The next command can be accepted in the cycle after the response register loads,
// so commands never overlap in the datapath; the memory read port sets the search time.
// Reset empties the queue (head and count zero); no memory clearing pass runs.
// When the receiver stalls, the response word holds in its output register and
// the next command is still accepted, then waits for that register to drain.
`default_nettype none

module array_deque_with_search_core
#(
    parameter int CAPACITY = 1024
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_cmd_if.sink    cmd,
    deq_rsp_if.source  rsp
);

    deq_pkg::ctrl_cmd_t ctl;
    deq_pkg::dp_stat_t  stat;

    deq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    deq_dp
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcode       (cmd.opcode),
        .value        (cmd.value),
        .ctl          (ctl),
        .stat         (stat),
        .result_value (rsp.result_value),
        .found        (rsp.found),
        .status       (rsp.status),
        .entry_count  (rsp.entry_count)
    );

endmodule

`default_nettype wire

// File: hw/rtl/deq_ctrl.sv
// Sequencing state machine for the queue: accept, execute, read, scan, respond.
`default_nettype none

module deq_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire deq_pkg::dp_stat_t   stat,
    output deq_pkg::ctrl_cmd_t       ctl
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.take   = 1'b1;
                    state_next = deq_pkg::S_EXEC;
                end
            end
            deq_pkg::S_EXEC:
            begin
                state_next = deq_pkg::S_DONE;
                if (stat.op inside {deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT})
                begin
                    if (stat.full)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.write = 1'b1;
                    end
                end
                else if (stat.op inside {deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK})
                begin
                    if (stat.empty)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.read   = 1'b1;
                        state_next = deq_pkg::S_READ;
                    end
                end
                else if (stat.op == deq_pkg::OP_SEARCH)
                begin
                    if (!stat.empty)
                    begin
                        ctl.read       = 1'b1;
                        ctl.scan_start = 1'b1;
                        state_next     = deq_pkg::S_SCAN;
                    end
                end
            end
            deq_pkg::S_READ:
            begin
                ctl.pop_capture = 1'b1;
                ctl.pop_commit  = 1'b1;
                state_next      = deq_pkg::S_DONE;
            end
            deq_pkg::S_SCAN:
            begin
                ctl.scan_next = 1'b1;
                if (stat.scan_hit)
                begin
                    ctl.set_found = 1'b1;
                    state_next    = deq_pkg::S_DONE;
                end
                else if (stat.scan_done)
                begin
                    state_next = deq_pkg::S_DONE;
                end
            end
            deq_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == deq_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/deq_dp.sv
// Queue datapath: ring store, head and count, scan pointer and response registers.
`default_nettype none

module deq_dp
#(
    parameter int CAPACITY = 1024
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [deq_pkg::OPCODE_W-1:0]        opcode,
    input  wire logic signed [deq_pkg::VALUE_W-1:0]  value,
    input  wire deq_pkg::ctrl_cmd_t                  ctl,
    output deq_pkg::dp_stat_t                        stat,
    output logic signed [deq_pkg::VALUE_W-1:0]       result_value,
    output logic                                     found,
    output logic [deq_pkg::STATUS_W-1:0]             status,
    output logic [deq_pkg::COUNT_W-1:0]              entry_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > deq_pkg::COUNT_W) ? CNT_W : deq_pkg::COUNT_W;

    logic [deq_pkg::VALUE_W-1:0]         mem [CAPACITY];
    logic [deq_pkg::VALUE_W-1:0]         rdata_reg;

    logic [deq_pkg::OPCODE_W-1:0]        op_reg;
    logic [deq_pkg::VALUE_W-1:0]         value_reg;
    logic [IDX_W-1:0]                    head_reg;
    logic [IDX_W-1:0]                    head_next;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic [CNT_W-1:0]                    k_reg;
    logic [CNT_W-1:0]                    k_next;
    logic                                pend_reg;
    logic                                pend_next;

    logic [deq_pkg::VALUE_W-1:0]         res_value_reg;
    logic                                found_reg;
    logic [deq_pkg::STATUS_W-1:0]        status_reg;
    logic signed [deq_pkg::VALUE_W-1:0]  out_value_reg;
    logic                                out_found_reg;
    logic [deq_pkg::STATUS_W-1:0]        out_status_reg;
    logic [deq_pkg::COUNT_W-1:0]         out_count_reg;

    logic [CNT_W-1:0]                    offset;
    logic [IDX_W:0]                      slot_sum;
    logic [IDX_W:0]                      slot_wrap;
    logic [IDX_W-1:0]                    head_dec;
    logic [IDX_W-1:0]                    head_inc;
    logic [IDX_W-1:0]                    addr;
    logic                                k_more;
    logic                                rd_en;
    logic [EXT_W-1:0]                    count_ext;

    always_comb
    begin
        if (ctl.scan_next)
        begin
            offset = k_reg;
        end
        else
        begin
            case (op_reg)
                deq_pkg::OP_PUSH_BACK: offset = count_reg;
                deq_pkg::OP_POP_BACK:  offset = count_reg - 1'b1;
                default:               offset = '0;
            endcase
        end
    end

    assign slot_sum  = {1'b0, head_reg} + {1'b0, offset[IDX_W-1:0]};
    assign slot_wrap = (slot_sum >= (IDX_W+1)'(CAPACITY)) ?
                       slot_sum - (IDX_W+1)'(CAPACITY) : slot_sum;
    assign head_dec  = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc  = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign addr      = (!ctl.scan_next && op_reg == deq_pkg::OP_PUSH_FRONT) ?
                       head_dec : slot_wrap[IDX_W-1:0];
    assign k_more    = (k_reg < count_reg);
    assign rd_en     = ctl.read || (ctl.scan_next && k_more);
    assign count_ext = EXT_W'(count_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            mem[addr] <= value_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        pend_next  = pend_reg;
        if (ctl.write)
        begin
            count_next = count_reg + 1'b1;
            if (op_reg == deq_pkg::OP_PUSH_FRONT)
            begin
                head_next = head_dec;
            end
        end
        if (ctl.pop_commit)
        begin
            count_next = count_reg - 1'b1;
            if (op_reg == deq_pkg::OP_POP_FRONT)
            begin
                head_next = head_inc;
            end
        end
        if (ctl.scan_start)
        begin
            k_next    = CNT_W'(1);
            pend_next = 1'b1;
        end
        else if (ctl.scan_next)
        begin
            if (k_more)
            begin
                k_next = k_reg + 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            op_reg        <= opcode;
            value_reg     <= value;
            res_value_reg <= '0;
            found_reg     <= 1'b0;
            status_reg    <= deq_pkg::ST_OK;
        end
        if (ctl.pop_capture)
        begin
            res_value_reg <= rdata_reg;
        end
        if (ctl.set_found)
        begin
            found_reg <= 1'b1;
        end
        if (ctl.set_status)
        begin
            status_reg <= ctl.status;
        end
        if (ctl.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_found_reg  <= found_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= count_ext[deq_pkg::COUNT_W-1:0];
        end
    end

    assign stat.op        = op_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg >= CNT_W'(CAPACITY));
    assign stat.scan_hit  = pend_reg && (rdata_reg == value_reg);
    assign stat.scan_done = !pend_reg;

    assign result_value = out_value_reg;
    assign found        = out_found_reg;
    assign status       = out_status_reg;
    assign entry_count  = out_count_reg;

endmodule

`default_nettype wire

// File: hw/rtl/deq_checker.sv
// Port-level checks on the queue response channel, bound to the top level.
`default_nettype none

module deq_checker
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                rsp_valid,
    input wire logic                                rsp_ready,
    input wire logic signed [deq_pkg::VALUE_W-1:0]  result_value,
    input wire logic                                found,
    input wire logic [deq_pkg::STATUS_W-1:0]        status,
    input wire logic [deq_pkg::COUNT_W-1:0]         entry_count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
        $stable({result_value, found, status, entry_count}))
        else $error("response word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == deq_pkg::ST_OK || status == deq_pkg::ST_FULL ||
        status == deq_pkg::ST_EMPTY)
        else $error("response status outside defined codes");

    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == deq_pkg::ST_EMPTY |->
        result_value == '0 && !found && entry_count == '0)
        else $error("empty status with nonzero fields");

    a_found_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> status == deq_pkg::ST_OK && result_value == '0)
        else $error("search hit with bad status or value");

    a_full_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == deq_pkg::ST_FULL |-> !found && result_value == '0)
        else $error("full status with nonzero fields");

endmodule

bind array_deque_with_search_core deq_checker u_deq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_value (rsp.result_value),
    .found        (rsp.found),
    .status       (rsp.status),
    .entry_count  (rsp.entry_count)
);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking bench for the deque core: random commands, responses checked in order.

module tb_top;

    localparam int VALUE_W      = deq_pkg::VALUE_W;
    localparam int OPCODE_W     = deq_pkg::OPCODE_W;
    localparam int STATUS_W     = deq_pkg::STATUS_W;
    localparam int COUNT_W      = deq_pkg::COUNT_W;
    localparam int CAPACITY     = 1024;
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int GAP_MAX      = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int MIXED_ITEMS  = 120;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic                      found;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        entry_count;
    } rsp_word_t;

    class deque_scoreboard;
        logic signed [VALUE_W-1:0] held[$];
        rsp_word_t                 pending[$];
        int errors;
        int checked;
        int refused_push;
        int refused_pop;
        int hits;
        int peak;

        function void note_command(logic [OPCODE_W-1:0] op, logic signed [VALUE_W-1:0] val);
            rsp_word_t w;
            w = '0;
            case (op)
                deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT:
                begin
                    if (held.size() >= CAPACITY)
                    begin
                        w.status = deq_pkg::ST_FULL;
                        refused_push++;
                    end
                    else if (op == deq_pkg::OP_PUSH_BACK)
                        held.push_back(val);
                    else
                        held.push_front(val);
                end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
                begin
                    if (held.size() == 0)
                    begin
                        w.status = deq_pkg::ST_EMPTY;
                        refused_pop++;
                    end
                    else if (op == deq_pkg::OP_POP_FRONT)
                        w.result_value = held.pop_front();
                    else
                        w.result_value = held.pop_back();
                end
                deq_pkg::OP_SEARCH:
                begin
                    foreach (held[k])
                    begin
                        if (held[k] == val)
                            w.found = 1'b1;
                    end
                    if (w.found)
                        hits++;
                end
                default:
                begin
                end
            endcase
            w.entry_count = COUNT_W'(held.size());
            if (held.size() > peak)
                peak = held.size();
            pending.push_back(w);
        endfunction

        function logic signed [VALUE_W-1:0] some_held();
            if (held.size() == 0)
                return '0;
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_response(rsp_word_t got);
            rsp_word_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: response word with none expected, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = pending.pop_front();
            checked++;
            compare_field("result_value", VALUE_W'(want.result_value),
                          VALUE_W'(got.result_value));
            compare_field("found", VALUE_W'(want.found), VALUE_W'(got.found));
            compare_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
            compare_field("entry_count", VALUE_W'(want.entry_count),
                          VALUE_W'(got.entry_count));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rsp_hold = 1'b0;
    int   issued = 0;
    int   rsp_count = 0;
    int   cycles = 0;

    deque_scoreboard sb = new();

    deq_cmd_if cmd_bus();
    deq_rsp_if rsp_bus();

    array_deque_with_search_core #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(VALUE_W-1){1'b0}}};
            1: return {1'b0, {(VALUE_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            4: return VALUE_W'($urandom_range(0, 7));
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    task automatic send_cmd(input logic [OPCODE_W-1:0] op,
                            input logic signed [VALUE_W-1:0] val);
        int gap;
        gap = $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.opcode <= op;
        cmd_bus.value  <= val;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        sb.note_command(op, val);
        issued++;
    endtask

    task automatic run_mixed(input int n);
        int pick;
        logic [OPCODE_W-1:0] op;
        logic signed [VALUE_W-1:0] val;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            val = draw_value();
            if (pick < 22)
                op = deq_pkg::OP_PUSH_BACK;
            else if (pick < 44)
                op = deq_pkg::OP_PUSH_FRONT;
            else if (pick < 62)
                op = deq_pkg::OP_POP_FRONT;
            else if (pick < 80)
                op = deq_pkg::OP_POP_BACK;
            else if (pick < 95)
            begin
                op = deq_pkg::OP_SEARCH;
                if (pick < 88 && sb.held.size() > 0)
                    val = sb.some_held();
            end
            else
                op = OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            send_cmd(op, val);
        end
    endtask

    task automatic run_fill();
        int pick;
        while (sb.held.size() < CAPACITY)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                send_cmd(deq_pkg::OP_SEARCH,
                         ($urandom_range(0, 1) == 0) ? sb.some_held() : draw_value());
            else if (pick < 8)
                send_cmd(deq_pkg::OP_PUSH_BACK, draw_value());
            else
                send_cmd(deq_pkg::OP_PUSH_FRONT, draw_value());
        end
    endtask

    initial
    begin : cmd_side
        rst_n          <= 1'b0;
        cmd_bus.valid  <= 1'b0;
        cmd_bus.opcode <= deq_pkg::OP_PUSH_BACK;
        cmd_bus.value  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, unused codes, extremes, ring wrap at the front
        send_cmd(deq_pkg::OP_POP_FRONT, 32'h1234_5678);
        send_cmd(deq_pkg::OP_POP_BACK, '1);
        send_cmd(deq_pkg::OP_SEARCH, '0);
        for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
            send_cmd(OPCODE_W'(c), '1);
        send_cmd(deq_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF);
        send_cmd(deq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        send_cmd(deq_pkg::OP_PUSH_BACK, '0);
        send_cmd(deq_pkg::OP_PUSH_FRONT, '1);
        send_cmd(deq_pkg::OP_SEARCH, 32'sh8000_0000);
        send_cmd(deq_pkg::OP_POP_BACK, '0);
        send_cmd(deq_pkg::OP_POP_FRONT, '0);

        run_mixed(MIXED_ITEMS);
        run_fill();

        // full store: refused pushes, search hit and miss, pops from both ends
        send_cmd(deq_pkg::OP_PUSH_BACK, draw_value());
        send_cmd(deq_pkg::OP_PUSH_FRONT, draw_value());
        send_cmd(deq_pkg::OP_SEARCH, sb.some_held());
        send_cmd(deq_pkg::OP_SEARCH, draw_value());
        run_mixed(MIXED_ITEMS);

        cmd_bus.valid <= 1'b0;
        wait (rsp_count == issued);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands and checked %0d response words, including %0d refused pushes,",
                 issued, sb.checked, sb.refused_push);
        $display("%0d refused pops, %0d search hits, peak occupancy %0d, and a long receiver stall.",
                 sb.refused_pop, sb.hits, sb.peak);
        if (sb.errors == 0 && sb.pending.size() == 0 && rsp_count == issued)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : rsp_side
        int        wait_cycles;
        rsp_word_t got;
        rsp_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = $urandom_range(0, GAP_MAX);
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clk);
            while (rsp_hold)
                @(posedge clk);
            rsp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_bus.valid !== 1'b1);
            got.result_value = rsp_bus.result_value;
            got.found        = rsp_bus.found;
            got.status       = rsp_bus.status;
            got.entry_count  = rsp_bus.entry_count;
            sb.check_response(got);
            rsp_count++;
        end
    end

    initial
    begin : hold_side
        wait (issued >= HOLD_AFTER);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

endmodule

// File: sim.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_if.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_dp.sv
hw/rtl/array_deque_with_search_core.sv
hw/rtl/deq_checker.sv
dv/tb_top.sv
